// File: sv/rlbd_pkg.sv
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared types and constants for the run-length byte decoder.
// ----------------------------------------------------------------------------
package rlbd_pkg;

    // Lanes per repeat beat, before clamping into 1..8.
    localparam int BEAT_BYTES = 8;
    localparam int LANES      = (BEAT_BYTES < 1) ? 1 : ((BEAT_BYTES > 8) ? 8 : BEAT_BYTES);

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int BEAT_W  = 64;

    localparam logic [BYTE_W-1:0]  REPEAT_BASE = 8'd128;
    localparam logic [COUNT_W-1:0] BEAT_LANES  = COUNT_W'(LANES);
    localparam logic [COUNT_W-1:0] ONE_LANE    = 4'd1;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_REPEAT,
        ST_LITERAL,
        ST_DRAIN
    } t_state;

    // Request to the shared beat unit.
    typedef struct packed {
        logic [BYTE_W-1:0] left;    // bytes still to produce
        logic [BYTE_W-1:0] value;   // byte to place in the lanes
        logic              single;  // one lane only (literal copy)
    } t_beat_req;

    // Answer of the shared beat unit.
    typedef struct packed {
        logic [BEAT_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  rest;
        logic               last;
    } t_beat_rsp;

endpackage

// File: sv/rlbd_if.sv
// ----------------------------------------------------------------------------
// rlbd_if
// Valid/ready channels of the run-length byte decoder.
// ----------------------------------------------------------------------------
interface rlbd_in_if;
    import rlbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              end_of_channel;

    modport source (output valid, output code_byte, output end_of_channel, input ready);
    modport sink   (input valid, input code_byte, input end_of_channel, output ready);
endinterface

interface rlbd_out_if;
    import rlbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BEAT_W-1:0]  pixel_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               run_last;

    modport source (output valid, output pixel_bytes, output byte_count, output run_last,
                    input ready);
    modport sink   (input valid, input pixel_bytes, input byte_count, input run_last,
                    output ready);
endinterface

// File: sv/rlbd_beat_unit.sv
// ----------------------------------------------------------------------------
// rlbd_beat_unit
// Shared compare/subtract unit: takes up to one beat of bytes off a count.
// ----------------------------------------------------------------------------
module rlbd_beat_unit import rlbd_pkg::*; (
    input  t_beat_req i_req,
    output t_beat_rsp o_rsp
);

    logic [COUNT_W-1:0] lanes;
    logic [COUNT_W-1:0] count;

    always_comb begin
        lanes = i_req.single ? ONE_LANE : BEAT_LANES;
        // Take the smaller of what is left and one beat.
        if ({4'b0, lanes} > i_req.left) begin
            count = i_req.left[COUNT_W-1:0];
        end else begin
            count = lanes;
        end
        o_rsp.count = count;
        o_rsp.rest  = i_req.left - {4'b0, count};
        o_rsp.last  = i_req.single || (o_rsp.rest == '0);
        for (int i = 0; i < BEAT_W / BYTE_W; i++) begin
            o_rsp.data[i*BYTE_W +: BYTE_W] = (COUNT_W'(i) < count) ? i_req.value : '0;
        end
    end

endmodule

// File: sv/run_length_byte_decoder.sv
// ----------------------------------------------------------------------------
// run_length_byte_decoder
// Byte run-length decoder for one image channel: header bytes select a
// repeat run or a literal copy; decoded bytes leave in packed beats.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+------------
//  i_in     | in  | code_byte[7:0], end_of_channel           | valid/ready
//  o_out    | out | pixel_bytes[63:0], byte_count[3:0],      | valid/ready
//           |     | run_last                                 |
//
// Header and literal items are taken while the output slot is free. A repeat
// item of n bytes leaves as 1 to 16 beats, one beat per cycle while o_out
// is not stalled, through the shared beat unit into the output register; the
// input is held off meanwhile. A stall on o_out holds the output register and
// stops the sequencer. Reset (i_rst_n low, synchronous) returns to header mode
// with an empty output register.
// ----------------------------------------------------------------------------
module run_length_byte_decoder import rlbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlbd_in_if.sink     i_in,
    rlbd_out_if.source  o_out
);

    // Sequencer state: decode mode plus the drain step of a repeat run.
    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_left,  n_left;
    logic [BYTE_W-1:0] r_byte,  n_byte;

    // Output register.
    logic               r_valid, n_valid;
    logic [BEAT_W-1:0]  r_data,  n_data;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_last,  n_last;

    t_beat_req unit_req;
    t_beat_rsp unit_rsp;

    logic slot_free;
    logic in_fire;

    rlbd_beat_unit u_beat (
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    // The output register can take a new beat when empty or being emptied.
    assign slot_free   = !r_valid || o_out.ready;
    assign i_in.ready  = (r_state != ST_DRAIN) && slot_free;
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid       = r_valid;
    assign o_out.pixel_bytes = r_data;
    assign o_out.byte_count  = r_count;
    assign o_out.run_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_data  <= n_data;
        r_count <= n_count;
        r_last  <= n_last;
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_byte  = r_byte;
        n_valid = r_valid && !o_out.ready;
        n_data  = r_data;
        n_count = r_count;
        n_last  = r_last;

        // Feed the shared unit: the held byte while draining, else the new item.
        unit_req.left   = r_left;
        unit_req.value  = (r_state == ST_DRAIN) ? r_byte : i_in.code_byte;
        unit_req.single = (r_state == ST_LITERAL);

        case (r_state)
            ST_HEADER: begin
                if (in_fire) begin
                    if (i_in.code_byte > REPEAT_BASE) begin
                        n_state = ST_REPEAT;
                        n_left  = i_in.code_byte - REPEAT_BASE;
                    end else if (i_in.code_byte != '0) begin
                        n_state = ST_LITERAL;
                        n_left  = i_in.code_byte;
                    end else begin
                        n_left  = '0;
                    end
                end
            end
            ST_LITERAL: begin
                if (in_fire) begin
                    n_valid = 1'b1;
                    n_data  = unit_rsp.data;
                    n_count = unit_rsp.count;
                    n_last  = 1'b1;
                    n_left  = unit_rsp.rest;
                    if (unit_rsp.rest == '0) begin
                        n_state = ST_HEADER;
                    end
                end
            end
            ST_REPEAT: begin
                if (in_fire) begin
                    n_byte = i_in.code_byte;
                    n_left = unit_rsp.rest;
                    // A run is never empty after a header; guard anyway.
                    if (r_left != '0) begin
                        n_valid = 1'b1;
                        n_data  = unit_rsp.data;
                        n_count = unit_rsp.count;
                        n_last  = unit_rsp.last;
                    end
                    n_state = (unit_rsp.rest == '0) ? ST_HEADER : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Advance one beat per free output slot.
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_data  = unit_rsp.data;
                    n_count = unit_rsp.count;
                    n_last  = unit_rsp.last;
                    n_left  = unit_rsp.rest;
                    if (unit_rsp.rest == '0) begin
                        n_state = ST_HEADER;
                    end
                end
            end
            default: begin
                n_state = ST_HEADER;
                n_left  = '0;
            end
        endcase

        // End of channel: drop a header taken with it or any pending literal count,
        // back to header mode. A repeat run still drains its beats first.
        if (in_fire && i_in.end_of_channel && (r_state != ST_REPEAT)) begin
            n_state = ST_HEADER;
            n_left  = '0;
        end
    end

endmodule

// File: sv/rlbd_checker.sv
// ----------------------------------------------------------------------------
// rlbd_checker
// Port-level checks for the run-length byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlbd_checker import rlbd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [BEAT_W-1:0]  i_pixel_bytes,
    input logic [COUNT_W-1:0] i_byte_count,
    input logic               i_run_last
);

    // A stalled beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_bytes) && $stable(i_byte_count)
            && $stable(i_run_last))
        else $error("stalled beat changed");

    // Every beat carries one to LANES bytes.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_byte_count >= ONE_LANE) && (i_byte_count <= BEAT_LANES))
        else $error("byte count out of range");

    // No item is taken while a finished beat sits stalled.
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("item accepted over a stalled beat");

    // A run that is not finished keeps the input held off.
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_run_last |-> !i_in_ready)
        else $error("input taken in the middle of a run");

endmodule

bind run_length_byte_decoder rlbd_checker u_rlbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_pixel_bytes (o_out.pixel_bytes),
    .i_byte_count  (o_out.byte_count),
    .i_run_last    (o_out.run_last)
);

// File: test/run_length_byte_decoder_tb.sv
// ----------------------------------------------------------------------------
// run_length_byte_decoder_tb
// Self-checking bench for the run-length byte decoder. It feeds directed
// and random compressed streams, predicts every output beat in a
// scoreboard, and compares each accepted beat with the oldest prediction.
// ----------------------------------------------------------------------------
module run_length_byte_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlbd_pkg::*;

    localparam int ITEM_TARGET = 330;  // stop random stimulus near this count
    localparam int STALL_LIMIT = 3000; // cycles without any accepted item
    localparam int QUIET_TAIL  = 40;   // cycles to watch after the last beat

    // One predicted output beat.
    typedef struct packed {
        logic [BEAT_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_pixel_beat;

    // Scoreboard: tracks the decoder state, predicts beats, checks results.
    class pixel_beat_scoreboard;
        t_state            mode;
        logic [BYTE_W-1:0] left;
        t_pixel_beat       pending_beats[$];
        int                mismatches;

        function new();
            mode       = ST_HEADER;
            left       = '0;
            mismatches = 0;
        endfunction

        // Predict the beats caused by one accepted code byte.
        function void note_input(logic [BYTE_W-1:0] code, logic eoc);
            t_pixel_beat beat;
            int          rest;
            int          lanes;
            rest = 0;
            case (mode)
                ST_REPEAT: begin
                    rest = int'(left);
                    while (rest > 0) begin
                        lanes      = (rest < LANES) ? rest : LANES;
                        beat.data  = '0;
                        for (int lane = 0; lane < lanes; lane++)
                            beat.data[BYTE_W*lane +: BYTE_W] = code;
                        beat.count = COUNT_W'(lanes);
                        rest       = rest - lanes;
                        beat.last  = (rest == 0);
                        pending_beats.push_back(beat);
                    end
                    mode = ST_HEADER;
                    left = '0;
                end
                ST_LITERAL: begin
                    beat.data  = BEAT_W'(code);
                    beat.count = ONE_LANE;
                    beat.last  = 1'b1;
                    pending_beats.push_back(beat);
                    left = left - 1'b1;
                    if (left == '0)
                        mode = ST_HEADER;
                end
                default: begin
                    // header mode, and the unused drain code treated alike
                    if (code > REPEAT_BASE) begin
                        mode = ST_REPEAT;
                        left = code - REPEAT_BASE;
                    end else if (code != '0) begin
                        mode = ST_LITERAL;
                        left = code;
                    end else begin
                        mode = ST_HEADER;
                        left = '0;
                    end
                end
            endcase
            // end of channel wins over whatever the byte started
            if (eoc) begin
                mode = ST_HEADER;
                left = '0;
            end
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s", $time, what);
        endfunction

        // Compare one accepted beat with the oldest prediction.
        function void check_beat(logic [BEAT_W-1:0] data, logic [COUNT_W-1:0] count,
                                 logic last);
            t_pixel_beat want;
            if (pending_beats.size() == 0) begin
                report($sformatf("unexpected beat: data=%h count=%0d last=%b",
                                 data, count, last));
                return;
            end
            want = pending_beats.pop_front();
            if (want.data !== data || want.count !== count || want.last !== last)
                report($sformatf("beat mismatch: want data=%h count=%0d last=%b, got data=%h count=%0d last=%b",
                                 want.data, want.count, want.last, data, count, last));
        endfunction

        function void flag_leftovers();
            if (pending_beats.size() != 0)
                report($sformatf("%0d predicted beats never arrived", pending_beats.size()));
        endfunction

        function bit clean();
            return mismatches == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rlbd_in_if  in_ch ();
    rlbd_out_if out_ch ();

    run_length_byte_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pixel_beat_scoreboard sb = new();

    int items_sent   = 0;
    int stall_cycles = 0;
    bit gaps_on      = 1'b1;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Sink side: check each accepted beat, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_beat(out_ch.pixel_bytes, out_ch.byte_count, out_ch.run_last);
        out_ch.ready <= !gaps_on || ($urandom_range(99) >= 20);
    end

    // Count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: end the run when the channels stop moving.
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("run_length_byte_decoder_tb: FAIL");
        $finish;
    end

    // Offer one code byte, optionally after a random gap, and hold it
    // until the decoder takes it. Called right after a rising edge.
    task automatic send_code(input logic [BYTE_W-1:0] code, input logic eoc);
        if (gaps_on && $urandom_range(99) < 20) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.code_byte      <= code;
        in_ch.end_of_channel <= eoc;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(code, eoc);
        items_sent++;
        // long stretch with no gaps on either side in the middle of the run
        gaps_on <= (items_sent < 150) || (items_sent >= 230);
    endtask

    // Hold the input off until every predicted beat has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // One random packet: mostly well-formed runs and copies, some noise.
    task automatic send_random_packet();
        int kind;
        int len;
        int pick;
        logic eoc;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        if (kind < 40) begin
            // repeat run, short runs (1 to 16) as often as long ones (17 to 127)
            len = (pick < 50) ? $urandom_range(1, 16) : $urandom_range(17, 127);
            send_code(REPEAT_BASE + BYTE_W'(len), 1'b0);
            send_code(BYTE_W'($urandom_range(0, 255)), $urandom_range(99) < 8);
        end else if (kind < 80) begin
            // literal copy, sometimes cut short by end of channel
            len = (pick < 85) ? $urandom_range(1, 8)
                : (pick < 95) ? $urandom_range(9, 40) : $urandom_range(41, 128);
            send_code(BYTE_W'(len), 1'b0);
            for (int i = 0; i < len; i++) begin
                eoc = ($urandom_range(99) < 3) || (i == len - 1 && $urandom_range(99) < 10);
                send_code(BYTE_W'($urandom_range(0, 255)), eoc);
                if (eoc)
                    break;
            end
        end else if (kind < 88) begin
            send_code('0, $urandom_range(99) < 30);
        end else if (kind < 94) begin
            // header dropped by the end flag
            send_code(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end else begin
            // noise, closed by end of channel to resync
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                send_code(BYTE_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.code_byte      = '0;
        in_ch.end_of_channel = 1'b0;
        out_ch.ready         = 1'b0;
        i_rst_n              = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        send_code(8'd0, 1'b0);                          // zero header: nothing out
        send_code(8'd129, 1'b0);                        // shortest repeat
        send_code(8'hA5, 1'b0);
        send_code(8'd255, 1'b0);                        // longest repeat, 16 beats
        send_code(8'h3C, 1'b0);
        send_code(8'd136, 1'b0);                        // exactly one full beat
        send_code(8'hFF, 1'b0);
        send_code(8'd137, 1'b0);                        // one full beat plus one lane
        send_code(8'h00, 1'b0);
        send_code(8'd1, 1'b0);                          // shortest copy
        send_code(8'h5A, 1'b0);
        send_code(8'd128, 1'b0);                        // longest copy, cut by end flag
        send_code(8'h11, 1'b0);
        send_code(8'h22, 1'b0);
        send_code(8'h33, 1'b1);
        send_code(8'd200, 1'b1);                        // end flag on a header
        send_code(8'd0, 1'b1);
        send_code(8'd150, 1'b0);                        // end flag on the repeat byte
        send_code(8'h77, 1'b1);
        send_code(8'd2, 1'b0);                          // copy of lane extremes
        send_code(8'hFF, 1'b0);
        send_code(8'h00, 1'b0);

        // Let the directed traffic drain completely before the random part.
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 3)
                wait_drained();
            send_random_packet();
        end

        wait_drained();
        repeat (QUIET_TAIL) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.clean())
            $display("run_length_byte_decoder_tb: PASS");
        else
            $display("run_length_byte_decoder_tb: FAIL");
        $finish;
    end

endmodule
